[rtl/depth_hole_fill_median3x3_defines.svh]
// Assertion macros shared by the depth hole filling filter modules.
// Needs a clock named clock and a synchronous active-high reset named reset in scope.
// Defining NO_ASSERTIONS turns every macro into nothing.
`ifndef DEPTH_HOLE_FILL_MEDIAN3X3_DEFINES_SVH
`define DEPTH_HOLE_FILL_MEDIAN3X3_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition that holds at every clock edge outside reset.
`define DHF_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Implication checked in the same cycle.
`define DHF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define DHF_ASSERT(label, expr, msg)
`define DHF_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

[rtl/dhf_pkg.sv]
// Shared types, constants and helper functions of the depth hole filling filter.
// Used by dhf_front, dhf_queue, dhf_back and the top level; depends on nothing.
`default_nettype none

package dhf_pkg;

   // Defaults of the top-level parameters.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int DEPTH_BITS_DEF = 16;

   // Fixed field widths of the stream and configuration ports.
   localparam int PIX_W      = 16;
   localparam int DIM_W      = 11;
   localparam int MAX_HEIGHT = 1024;

   localparam logic [DIM_W-1:0] MIN_DIM      = 11'd3;
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

   // Configuration register indexes.
   localparam logic [0:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Queue between the window front end and the median back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Eight neighbours around the centre of the 3x3 window.
   localparam int NB_COUNT = 8;
   localparam int CNT_W    = $clog2(NB_COUNT + 1);
   localparam int KEY_W    = PIX_W + 1;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [KEY_W-1:0] key_type;
   typedef key_type [NB_COUNT-1:0] key_vec_type;

   // Frame edge masks and end-of-frame mark of one window position.
   typedef struct packed {
      logic last;
      logic top;
      logic bot;
      logic left;
      logic right;
   } edge_type;

   // One queued work item: centre sample and its masked neighbours.
   typedef struct packed {
      pix_type                centre;
      pix_type [NB_COUNT-1:0] nbr;
      logic                   last;
   } work_type;

   // Side information that travels along the sorting pipeline.
   typedef struct packed {
      pix_type          centre;
      logic [CNT_W-1:0] cnt;
      logic             last;
   } meta_type;

   // Odd-even merge sorting network for eight keys, six layers.
   localparam int NET_SIZE = 19;
   localparam int NET_A     [NET_SIZE] = '{0, 2, 4, 6, 0, 1, 4, 5, 1, 5, 0, 1, 2, 3, 2, 3, 1, 3, 5};
   localparam int NET_B     [NET_SIZE] = '{1, 3, 5, 7, 2, 3, 6, 7, 2, 6, 4, 5, 6, 7, 4, 5, 2, 4, 6};
   localparam int NET_LAYER [NET_SIZE] = '{0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 3, 3, 3, 3, 4, 4, 5, 5, 5};

   // Zero samples sort above every nonzero one.
   function automatic key_type to_key(input pix_type pix);
      return {(pix == '0), pix};
   endfunction

   // One layer of compare-exchange elements; the pairs of a layer are disjoint.
   function automatic key_vec_type sort_layer(input key_vec_type keys, input int layer);
      key_vec_type res;
      key_type     lo_k;
      key_type     hi_k;
      res = keys;
      for (int k = 0; k < NET_SIZE; k++) begin
         if (NET_LAYER[k] == layer) begin
            lo_k = res[NET_A[k]];
            hi_k = res[NET_B[k]];
            if (lo_k > hi_k) begin
               res[NET_A[k]] = hi_k;
               res[NET_B[k]] = lo_k;
            end
         end
      end
      return res;
   endfunction

   // True when the keys are in ascending order.
   function automatic logic keys_sorted(input key_vec_type keys);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < NB_COUNT - 1; k++) begin
         if (keys[k] > keys[k+1]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

[rtl/dhf_front.sv]
// Front end of the depth hole filling filter: frame position, two line stores,
// the 3x3 window and the edge classification. Depends on dhf_pkg and the defines header.
`default_nettype none
`include "depth_hole_fill_median3x3_defines.svh"

module dhf_front #(
   parameter int MAX_WIDTH  = dhf_pkg::MAX_WIDTH_DEF,
   parameter int DEPTH_BITS = dhf_pkg::DEPTH_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dhf_pkg::DIM_W-1:0]     image_width,
   input  logic [dhf_pkg::DIM_W-1:0]     image_height,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dhf_pkg::PIX_W-1:0]     req_tdata,
   input  logic                          req_tuser,
   input  logic [dhf_pkg::QCOUNT_W-1:0]  q_count,
   output logic                          push,
   output dhf_pkg::work_type             push_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CW     = COL_W + 1;
   localparam int WCMP_W = (CW > dhf_pkg::DIM_W) ? CW : dhf_pkg::DIM_W;
   localparam int WIN_N  = 9;
   localparam int CENTRE = 4;
   localparam int DIM_W  = dhf_pkg::DIM_W;
   localparam int QC_W   = dhf_pkg::QCOUNT_W;

   // Frame geometry clamped to the supported range.
   logic [WCMP_W-1:0] width_ext;
   logic [CW-1:0]     eff_width;
   logic [DIM_W-1:0]  eff_height;

   always_comb begin
      width_ext = WCMP_W'(image_width);
      if (image_width < dhf_pkg::MIN_DIM) begin
         eff_width = CW'(dhf_pkg::MIN_DIM);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         eff_width = CW'(MAX_WIDTH);
      end else begin
         eff_width = CW'(width_ext);
      end
      if (image_height < dhf_pkg::MIN_DIM) begin
         eff_height = dhf_pkg::MIN_DIM;
      end else if (image_height > DIM_W'(dhf_pkg::MAX_HEIGHT)) begin
         eff_height = DIM_W'(dhf_pkg::MAX_HEIGHT);
      end else begin
         eff_height = image_height;
      end
   end

   // Position of the next beat and the line store clearing pass.
   logic [COL_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic             clear_busy_ff;
   logic [COL_W-1:0] clr_addr_ff;

   // Stage one: line store read data and the item being written back.
   logic                    s1_valid_ff;
   logic                    s1_push_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic [DEPTH_BITS-1:0]   s1_sample_ff;
   dhf_pkg::edge_type       s1_edge_ff;
   logic [DEPTH_BITS-1:0]   rd_above_ff;
   logic [DEPTH_BITS-1:0]   rd_two_ff;
   logic                    fwd_hit_ff;
   logic [DEPTH_BITS-1:0]   fwd_sample_ff;
   logic [DEPTH_BITS-1:0]   fwd_above_ff;
   logic [DEPTH_BITS-1:0]   win_ff [WIN_N];

   logic                    req_accept;
   logic                    col_zero;
   logic                    col_one;
   logic [DEPTH_BITS-1:0]   sample_in;
   logic                    item_valid;
   logic [DIM_W-1:0]        centre_row;
   logic                    at_last_col;
   dhf_pkg::edge_type       edge_in;
   logic [CW-1:0]           col_inc;
   logic [QC_W:0]           occupancy;

   logic                    mem_we;
   logic [COL_W-1:0]        mem_addr;
   logic [DEPTH_BITS-1:0]   mem_above_wr;
   logic [DEPTH_BITS-1:0]   mem_two_wr;
   logic [DEPTH_BITS-1:0]   above_mem [MAX_WIDTH];
   logic [DEPTH_BITS-1:0]   two_mem [MAX_WIDTH];

   logic [DEPTH_BITS-1:0]   s1_above;
   logic [DEPTH_BITS-1:0]   s1_two;
   logic [DEPTH_BITS-1:0]   win_next [WIN_N];
   logic [DEPTH_BITS-1:0]   nb [WIN_N];

   // Room is counted for the item still in stage one.
   assign occupancy  = (QC_W+1)'(q_count) + (QC_W+1)'(s1_valid_ff && s1_push_ff);
   assign req_tready = !clear_busy_ff && (occupancy < (QC_W+1)'(dhf_pkg::QUEUE_DEPTH));
   assign req_accept = req_tvalid && req_tready;

   // Classify the incoming beat: sample value, whether it completes a centre, edges.
   always_comb begin
      col_zero = (col_ff == '0);
      col_one  = (col_ff == COL_W'(1));
      if (req_tuser || (row_ff >= eff_height)) begin
         sample_in = '0;
      end else begin
         sample_in = req_tdata[DEPTH_BITS-1:0];
      end
      if (col_zero) begin
         item_valid = (row_ff >= DIM_W'(2)) && ((row_ff - DIM_W'(2)) < eff_height);
         centre_row = row_ff - DIM_W'(2);
      end else begin
         item_valid = (row_ff >= DIM_W'(1)) && ((row_ff - DIM_W'(1)) < eff_height);
         centre_row = row_ff - DIM_W'(1);
      end
      at_last_col   = col_zero || (CW'(col_ff) == eff_width);
      edge_in.right = col_zero;
      edge_in.left  = col_one;
      edge_in.top   = (centre_row == '0);
      edge_in.bot   = (centre_row >= eff_height - DIM_W'(1));
      edge_in.last  = (centre_row == eff_height - DIM_W'(1)) && at_last_col;
   end

   // Next position: wrap at the row end, restart after the flush rows.
   always_comb begin
      col_inc = CW'(col_ff) + CW'(1);
      if (row_ff >= eff_height + DIM_W'(1)) begin
         col_in = '0;
         row_in = '0;
      end else if (col_inc >= eff_width) begin
         col_in = '0;
         row_in = row_ff + DIM_W'(1);
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         clear_busy_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s1_push_ff    <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (clear_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + COL_W'(1);
            if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
         s1_valid_ff <= req_accept;
         s1_push_ff  <= req_accept && item_valid;
         fwd_hit_ff  <= s1_valid_ff && (s1_col_ff == col_ff);
      end
   end

   // Stage one payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff    <= col_ff;
         s1_sample_ff <= sample_in;
         s1_edge_ff   <= edge_in;
      end
      fwd_sample_ff <= s1_sample_ff;
      fwd_above_ff  <= s1_above;
   end

   // Line stores: one write port shared by the clearing pass and stage one.
   always_comb begin
      mem_we = clear_busy_ff || s1_valid_ff;
      if (clear_busy_ff) begin
         mem_addr     = clr_addr_ff;
         mem_above_wr = '0;
         mem_two_wr   = '0;
      end else begin
         mem_addr     = s1_col_ff;
         mem_above_wr = s1_sample_ff;
         mem_two_wr   = s1_above;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         above_mem[mem_addr] <= mem_above_wr;
         two_mem[mem_addr]   <= mem_two_wr;
      end
      rd_above_ff <= above_mem[col_ff];
      rd_two_ff   <= two_mem[col_ff];
   end

   // Read data, bypassed when the previous beat wrote the same column.
   assign s1_above = fwd_hit_ff ? fwd_sample_ff : rd_above_ff;
   assign s1_two   = fwd_hit_ff ? fwd_above_ff  : rd_two_ff;

   // Window shift and frame edge masking.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_next[k*3]     = win_ff[k*3 + 1];
         win_next[k*3 + 1] = win_ff[k*3 + 2];
      end
      win_next[2] = s1_two;
      win_next[5] = s1_above;
      win_next[8] = s1_sample_ff;
      for (int k = 0; k < WIN_N; k++) begin
         nb[k] = win_next[k];
      end
      if (s1_edge_ff.right) begin
         nb[2] = '0;
         nb[5] = '0;
         nb[8] = '0;
      end
      if (s1_edge_ff.left) begin
         nb[0] = '0;
         nb[3] = '0;
         nb[6] = '0;
      end
      if (s1_edge_ff.top) begin
         nb[0] = '0;
         nb[1] = '0;
         nb[2] = '0;
      end
      if (s1_edge_ff.bot) begin
         nb[6] = '0;
         nb[7] = '0;
         nb[8] = '0;
      end
      push_data.centre = dhf_pkg::PIX_W'(nb[CENTRE]);
      for (int j = 0; j < dhf_pkg::NB_COUNT; j++) begin
         push_data.nbr[j] = dhf_pkg::PIX_W'(nb[(j < CENTRE) ? j : j + 1]);
      end
      push_data.last = s1_edge_ff.last;
   end

   assign push = s1_valid_ff && s1_push_ff;

   // The window shifts on every beat that passes stage one.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_N; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int k = 0; k < WIN_N; k++) begin
            win_ff[k] <= win_next[k];
         end
      end
   end

   // The stored column always addresses a real line store entry.
   `DHF_ASSERT(a_col_in_range, int'(col_ff) < MAX_WIDTH, "column position beyond line store")
   // The credit check keeps the queue from overflowing.
   `DHF_ASSERT_IMP(a_no_overflow, push, int'(q_count) < dhf_pkg::QUEUE_DEPTH, "push into full queue")
   // The clearing pass owns the write port alone.
   `DHF_ASSERT_IMP(a_clear_exclusive, clear_busy_ff, !s1_valid_ff, "beat in flight while clearing")

endmodule

`default_nettype wire

[rtl/dhf_queue.sv]
// Short queue of classified work items between the window front end and the median back end.
// Depends on dhf_pkg.
`default_nettype none

module dhf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  dhf_pkg::work_type             push_data,
   input  logic                          pop,
   output dhf_pkg::work_type             head,
   output logic                          not_empty,
   output logic [dhf_pkg::QCOUNT_W-1:0]  count
);

   localparam int DEPTH = dhf_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int QC_W  = dhf_pkg::QCOUNT_W;

   dhf_pkg::work_type entry_mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   count_ff, count_in;
   logic              do_pop;

   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign head      = entry_mem[rd_ptr_ff];
   assign count     = count_ff;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QC_W'(push) - QC_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/dhf_back.sv]
// Back end of the depth hole filling filter: sorting network over the eight neighbours,
// median pick with rounding and the output register. Depends on dhf_pkg and the defines header.
`default_nettype none
`include "depth_hole_fill_median3x3_defines.svh"

module dhf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dhf_pkg::work_type          head,
   input  logic                       head_valid,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [dhf_pkg::PIX_W-1:0]  rsp_tdata,   // depth_out
   output logic [1:0]                 rsp_tuser,   // was_hole, still_zero
   output logic                       rsp_tlast    // last_of_frame
);

   localparam int PIX_W = dhf_pkg::PIX_W;
   localparam int CNT_W = dhf_pkg::CNT_W;
   localparam int IDX_W = $clog2(dhf_pkg::NB_COUNT);

   logic                  advance;

   logic                  b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   dhf_pkg::key_vec_type  b1_keys_ff, b2_keys_ff, b3_keys_ff;
   dhf_pkg::meta_type     b1_meta_ff, b2_meta_ff, b3_meta_ff, b4_meta_ff;
   dhf_pkg::pix_type      b4_lo_ff, b4_hi_ff;

   logic                  rsp_valid_ff;
   dhf_pkg::pix_type      rsp_data_ff;
   logic                  rsp_hole_ff;
   logic                  rsp_zero_ff;
   logic                  rsp_last_ff;

   dhf_pkg::key_vec_type  keys0;
   dhf_pkg::key_vec_type  b1_keys_in, b2_keys_in, b3_keys_in;
   dhf_pkg::meta_type     b1_meta_in;
   logic [IDX_W-1:0]      half_idx;
   logic [IDX_W-1:0]      lo_idx;
   logic [PIX_W:0]        pair_sum;
   dhf_pkg::pix_type      pair_avg;
   dhf_pkg::pix_type      median;
   logic                  is_hole;
   logic                  no_nbr;

   // The whole pipeline moves unless a finished beat waits at the output.
   assign advance = !rsp_valid_ff || rsp_tready;
   assign pop     = advance && head_valid;

   // Stage one: keys, nonzero count, first two sorting layers; stages two and three: two each.
   always_comb begin
      b1_meta_in.centre = head.centre;
      b1_meta_in.last   = head.last;
      b1_meta_in.cnt    = '0;
      for (int j = 0; j < dhf_pkg::NB_COUNT; j++) begin
         keys0[j]       = dhf_pkg::to_key(head.nbr[j]);
         b1_meta_in.cnt = b1_meta_in.cnt + CNT_W'(head.nbr[j] != '0);
      end
      b1_keys_in = dhf_pkg::sort_layer(dhf_pkg::sort_layer(keys0, 0), 1);
      b2_keys_in = dhf_pkg::sort_layer(dhf_pkg::sort_layer(b1_keys_ff, 2), 3);
      b3_keys_in = dhf_pkg::sort_layer(dhf_pkg::sort_layer(b2_keys_ff, 4), 5);
   end

   // Stage four: the two middle nonzero values (the same one for an odd count).
   always_comb begin
      half_idx = b3_meta_ff.cnt[CNT_W-1:1];
      lo_idx   = b3_meta_ff.cnt[0] ? half_idx : half_idx - IDX_W'(1);
   end

   // Output stage: average with round half to even, choose centre or median.
   always_comb begin
      pair_sum = {1'b0, b4_lo_ff} + {1'b0, b4_hi_ff};
      pair_avg = pair_sum[PIX_W:1];
      if (pair_sum[0] && pair_avg[0]) begin
         median = pair_avg + PIX_W'(1);
      end else begin
         median = pair_avg;
      end
      is_hole = (b4_meta_ff.centre == '0);
      no_nbr  = (b4_meta_ff.cnt == '0);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= head_valid;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         rsp_valid_ff <= b4_valid_ff;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         b1_keys_ff  <= b1_keys_in;
         b1_meta_ff  <= b1_meta_in;
         b2_keys_ff  <= b2_keys_in;
         b2_meta_ff  <= b1_meta_ff;
         b3_keys_ff  <= b3_keys_in;
         b3_meta_ff  <= b2_meta_ff;
         b4_lo_ff    <= b3_keys_ff[lo_idx][PIX_W-1:0];
         b4_hi_ff    <= b3_keys_ff[half_idx][PIX_W-1:0];
         b4_meta_ff  <= b3_meta_ff;
         rsp_hole_ff <= is_hole;
         rsp_zero_ff <= is_hole && no_nbr;
         rsp_last_ff <= b4_meta_ff.last;
         if (!is_hole) begin
            rsp_data_ff <= b4_meta_ff.centre;
         end else if (no_nbr) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= median;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_zero_ff, rsp_hole_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The network leaves its keys in ascending order.
   `DHF_ASSERT_IMP(a_sorted, b3_valid_ff, dhf_pkg::keys_sorted(b3_keys_ff), "keys not sorted")
   // The two middle values are picked in order.
   `DHF_ASSERT_IMP(a_pair_order, b4_valid_ff && (b4_meta_ff.cnt != '0), b4_lo_ff <= b4_hi_ff, "middle pair out of order")
   // A hole without neighbours reads as zero and is marked as a hole.
   `DHF_ASSERT_IMP(a_still_zero, rsp_valid_ff && rsp_zero_ff, rsp_hole_ff && (rsp_data_ff == '0), "still_zero beat inconsistent")

endmodule

`default_nettype wire

[rtl/depth_hole_fill_median3x3.sv]
// Depth hole filling filter with a masked 3x3 median: top level with the configuration registers.
// Depends on dhf_pkg, dhf_front, dhf_queue, dhf_back and the defines header.
//
// Usage. Depth samples arrive in raster order on the req_ channel, one beat per pixel; a beat
// with req_tuser set is a padding beat. After the image_width*image_height pixels of a frame,
// image_width+1 padding beats drain the remaining results. Each beat on the rsp_ channel carries
// the filled centre pixel one row and one column behind the newest sample; rsp_tlast marks the
// frame's final pixel. Beats whose centre lies above the frame give no result.
// Configuration: csr_we with csr_addr 0 writes the width, 1 the height; written while idle.
// Throughput: one beat per cycle, sustained, in both directions, while rsp_tready stays high.
// Path: the beat that completes a window passes the line store read stage, the queue, four
// stages of sorting and median selection and the output register before its result leaves.
// Reset: the line stores are cleared one column per cycle, all MAX_WIDTH columns (1024 by default),
// with req_tready low; configuration writes are taken throughout.
// Stalls: when rsp_tready is low the back end holds, the four-entry queue fills, and req_tready
// falls once the queue and the beat in the line store stage would fill it.
`default_nettype none

module depth_hole_fill_median3x3 #(
   parameter int MAX_WIDTH  = dhf_pkg::MAX_WIDTH_DEF,
   parameter int DEPTH_BITS = dhf_pkg::DEPTH_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_addr,
   input  logic [dhf_pkg::DIM_W-1:0]  csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [dhf_pkg::PIX_W-1:0]  req_tdata,   // depth_in
   input  logic                       req_tuser,   // flush
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [dhf_pkg::PIX_W-1:0]  rsp_tdata,   // depth_out
   output logic [1:0]                 rsp_tuser,   // was_hole, still_zero
   output logic                       rsp_tlast    // last_of_frame
);

   logic [dhf_pkg::DIM_W-1:0]    image_width_ff, image_width_in;
   logic [dhf_pkg::DIM_W-1:0]    image_height_ff, image_height_in;

   logic                         push;
   dhf_pkg::work_type            push_data;
   logic                         pop;
   dhf_pkg::work_type            head;
   logic                         head_valid;
   logic [dhf_pkg::QCOUNT_W-1:0] q_count;

   // Configuration register writes.
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            dhf_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata;
            dhf_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= dhf_pkg::WIDTH_RESET;
         image_height_ff <= dhf_pkg::HEIGHT_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // Window front end.
   dhf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .q_count      (q_count),
      .push         (push),
      .push_data    (push_data)
   );

   // Work queue.
   dhf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (head_valid),
      .count     (q_count)
   );

   // Median back end.
   dhf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the depth hole filling filter with a masked 3x3 median.
// Depends on dhf_pkg and depth_hole_fill_median3x3; a behavioural predictor checks each rsp_ beat.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIX_W         = dhf_pkg::PIX_W;
   localparam int DIM_W         = dhf_pkg::DIM_W;
   localparam int MAX_WIDTH_DEF = dhf_pkg::MAX_WIDTH_DEF;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 16;
   localparam int RANDOM_ITEMS = 80;
   localparam int LEAD_ITEMS   = 20;
   localparam int EDGE_ITEMS   = 16;

   // One filled pixel as it leaves the block.
   typedef struct packed {
      logic [PIX_W-1:0] depth;
      logic             hole;
      logic             empty;
      logic             last;
   } fill_type;

   // One row of the directed table; typed marks a hand-written expectation.
   typedef struct packed {
      logic [PIX_W-1:0] depth;
      logic             flush;
      logic             typed;
      logic [PIX_W-1:0] w_depth;
      logic             w_hole;
      logic             w_empty;
      logic             w_last;
   } stim_row_type;

   localparam int DIR_COUNT = 26;

   // Two 3x3 frames. The first has one far sample, a lone near sample and large holes;
   // the second has ties for rounding, a flush beat inside the frame and noisy padding.
   localparam stim_row_type DIR_ROWS [DIR_COUNT] = '{
      '{16'd65535, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b1, 16'd65535, 1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b1, 16'd65535, 1'b1, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b1, 16'd0,     1'b1, 1'b1, 1'b0},
      '{16'd0,     1'b0, 1'b1, 16'd65535, 1'b1, 1'b0, 1'b0},
      '{16'd1,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b1, 1'b1, 16'd1,     1'b1, 1'b0, 1'b0},
      '{16'd0,     1'b1, 1'b1, 16'd0,     1'b1, 1'b1, 1'b0},
      '{16'd0,     1'b1, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b1, 1'b1, 16'd1,     1'b0, 1'b0, 1'b1},
      '{16'd3,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd4,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'hFFFF,  1'b1, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd7,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd5,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd6,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'hFFFF,  1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'h8000,  1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'd1,     1'b1, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
      '{16'h5555,  1'b0, 1'b0, 16'd0,     1'b0, 1'b0, 1'b0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [0:0]       csr_addr = dhf_pkg::CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [PIX_W-1:0] req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [PIX_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic             rsp_tlast;

   depth_hole_fill_median3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // depth_in
      .req_tuser  (req_tuser),   // flush
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // depth_out
      .rsp_tuser  (rsp_tuser),   // was_hole, still_zero
      .rsp_tlast  (rsp_tlast)    // last_of_frame
   );

   always #2 clock = ~clock;

   // Predictor state: line stores, window, position and register copies.
   logic [PIX_W-1:0] above_q     [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] two_above_q [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] win         [9];
   int unsigned      pos_row;
   int unsigned      pos_col;
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;

   fill_type fills_due [$];
   int    errors;
   int    beats_sent;
   int    results_seen;
   int    settings_used;
   int    send_idle_pct;
   int    recv_idle_pct;

   // A register value as the block uses it.
   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] val, input int unsigned hi);
      if (val < dhf_pkg::MIN_DIM) begin
         return dhf_pkg::MIN_DIM;
      end
      if (val > hi) begin
         return hi;
      end
      return val;
   endfunction

   // Advances the predictor by one accepted beat; returns 1 when a result is due.
   function automatic bit predict_fill(input logic [PIX_W-1:0] d, input logic f,
                                       output fill_type res);
      int unsigned      w, h, r, c, cr, cc, n, sum, avg, med;
      int               j;
      bit               hit;
      logic [PIX_W-1:0] v;
      logic [PIX_W-1:0] nb  [9];
      logic [PIX_W-1:0] srt [8];
      w = eff_dim(cfg_width, MAX_WIDTH_DEF);
      h = eff_dim(cfg_height, dhf_pkg::MAX_HEIGHT);
      r = pos_row;
      c = pos_col;
      if (c >= MAX_WIDTH_DEF) begin
         c = 0;
      end
      // Flush beats and anything below the frame count as holes.
      v = (f || r >= h) ? '0 : d;

      // Slide the window one column and pull the new column from the line stores.
      for (int k = 0; k < 3; k++) begin
         win[3*k]   = win[3*k+1];
         win[3*k+1] = win[3*k+2];
      end
      win[2] = two_above_q[c];
      win[5] = above_q[c];
      win[8] = v;
      two_above_q[c] = above_q[c];
      above_q[c] = v;
      nb = win;

      // Locate the centre and mask the neighbours that lie outside the frame.
      res = '0;
      if (c == 0) begin
         hit = (r >= 2) && (r - 2 < h);
         cr = r - 2;
         cc = w - 1;
         nb[2] = '0;
         nb[5] = '0;
         nb[8] = '0;
      end else begin
         hit = (r >= 1) && (r - 1 < h);
         cr = r - 1;
         cc = c - 1;
         if (c == 1) begin
            nb[0] = '0;
            nb[3] = '0;
            nb[6] = '0;
         end
      end

      if (hit) begin
         if (cr == 0) begin
            nb[0] = '0;
            nb[1] = '0;
            nb[2] = '0;
         end
         if (cr + 1 >= h) begin
            nb[6] = '0;
            nb[7] = '0;
            nb[8] = '0;
         end
         if (nb[4] != '0) begin
            res.depth = nb[4];
         end else begin
            // Sort the nonzero neighbours and take the middle, ties rounded half to even.
            n = 0;
            for (int k = 0; k < 9; k++) begin
               if (k != 4 && nb[k] != '0) begin
                  j = n;
                  while (j > 0 && srt[j-1] > nb[k]) begin
                     srt[j] = srt[j-1];
                     j--;
                  end
                  srt[j] = nb[k];
                  n++;
               end
            end
            if (n == 0) begin
               med = 0;
            end else if (n % 2 == 1) begin
               med = srt[n/2];
            end else begin
               sum = srt[n/2-1] + srt[n/2];
               avg = sum >> 1;
               if ((sum & 1) != 0 && (avg & 1) != 0) begin
                  avg++;
               end
               med = avg;
            end
            res.depth = med[PIX_W-1:0];
            res.hole = 1'b1;
            res.empty = (n == 0);
         end
         res.last = (cr == h - 1) && (cc == w - 1);
      end

      // Move to the next position; far below the frame it returns to the start.
      if (r >= h + 1) begin
         pos_row = 0;
         pos_col = 0;
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         pos_col = c;
         pos_row = r;
      end
      return hit;
   endfunction

   // Depth sample with plenty of holes, small values for ties and the full range.
   function automatic logic [PIX_W-1:0] rand_depth();
      case ($urandom_range(9))
         0, 1, 2, 3: return '0;
         4, 5, 6:    return PIX_W'($urandom_range(1, 8));
         7:          return PIX_W'($urandom_range(65528, 65535));
         default:    return PIX_W'($urandom_range(65535));
      endcase
   endfunction

   // Offers one beat, idling at random first, and records what it should cause.
   task automatic send_beat(input logic [PIX_W-1:0] d, input logic f, input logic typed,
                            input fill_type want);
      fill_type res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= f;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (predict_fill(d, f, res) && !typed) begin
         fills_due.push_back(res);
      end
      if (typed) begin
         fills_due.push_back(want);
      end
   endtask

   // Stops the input stream and waits until the block has drained.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (fills_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [DIM_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == dhf_pkg::CSR_IMAGE_WIDTH) begin
         cfg_width = val;
      end else begin
         cfg_height = val;
      end
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      settle();
      write_csr(dhf_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(dhf_pkg::CSR_IMAGE_HEIGHT, h);
      settings_used++;
   endtask

   // Streams random beats until the frame wraps, or until cut beats when cut is nonzero.
   task automatic stream_frame(input int cut);
      int               sent;
      int unsigned      h;
      logic [PIX_W-1:0] d;
      logic             f;
      sent = 0;
      do begin
         h = eff_dim(cfg_height, dhf_pkg::MAX_HEIGHT);
         if (pos_row < h) begin
            d = rand_depth();
            f = ($urandom_range(19) == 0);
         end else begin
            d = PIX_W'($urandom_range(65535));
            f = ($urandom_range(7) != 0);
         end
         send_beat(d, f, 1'b0, '0);
         sent++;
      end while (!(pos_row == 0 && pos_col == 0) && (cut == 0 || sent < cut));
   endtask

   // Receiver stalls are drawn afresh on every cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Each result beat is checked against the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      fill_type got;
      fill_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.depth = rsp_tdata;
         got.hole = rsp_tuser[0];
         got.empty = rsp_tuser[1];
         got.last = rsp_tlast;
         results_seen++;
         if (fills_due.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected: depth %0d hole %b empty %b last %b",
                     $time, got.depth, got.hole, got.empty, got.last);
         end else begin
            want = fills_due.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: mismatch, expected depth %0d hole %b empty %b last %b",
                        $time, want.depth, want.hole, want.empty, want.last);
               $display("%0t:           actual   depth %0d hole %b empty %b last %b",
                        $time, got.depth, got.hole, got.empty, got.last);
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results outstanding",
               CYCLE_LIMIT, fills_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int mark;
      int cut;
      errors = 0;
      beats_sent = 0;
      results_seen = 0;
      settings_used = 1;
      send_idle_pct = 35;
      recv_idle_pct = 60;
      for (int k = 0; k < MAX_WIDTH_DEF; k++) begin
         above_q[k] = '0;
         two_above_q[k] = '0;
      end
      for (int k = 0; k < 9; k++) begin
         win[k] = '0;
      end
      pos_row = 0;
      pos_col = 0;
      cfg_width = dhf_pkg::WIDTH_RESET;
      cfg_height = dhf_pkg::HEIGHT_RESET;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset dimensions: a short run into the first row, then both sizes drop to
      // the minimum mid-frame and the frame runs on to its end.
      stream_frame(LEAD_ITEMS);
      set_dims(dhf_pkg::MIN_DIM, dhf_pkg::MIN_DIM);
      stream_frame(0);

      // Directed table on the smallest frame.
      set_dims(dhf_pkg::MIN_DIM, dhf_pkg::MIN_DIM);
      for (int k = 0; k < DIR_COUNT; k++) begin
         send_beat(DIR_ROWS[k].depth, DIR_ROWS[k].flush, DIR_ROWS[k].typed,
                   '{DIR_ROWS[k].w_depth, DIR_ROWS[k].w_hole, DIR_ROWS[k].w_empty,
                     DIR_ROWS[k].w_last});
      end

      // Random frames under three idling patterns; the extreme sizes are touched
      // briefly without idling, each change after the first landing mid-frame.
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 60 : 0;
         recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 35 : 0;
         if (mode == 2) begin
            set_dims(11'd1024, 11'd3);
            stream_frame(EDGE_ITEMS);
            set_dims(11'd2047, 11'd0);
            stream_frame(EDGE_ITEMS);
            set_dims(11'd0, 11'd1024);
            stream_frame(EDGE_ITEMS);
            set_dims(11'd3, 11'd2047);
            stream_frame(EDGE_ITEMS);
            set_dims(dhf_pkg::MIN_DIM, dhf_pkg::MIN_DIM);
         end
         mark = beats_sent;
         while (beats_sent - mark < RANDOM_ITEMS) begin
            if ($urandom_range(1) == 1) begin
               set_dims(($urandom_range(7) == 0) ? DIM_W'($urandom_range(2))
                                                 : DIM_W'($urandom_range(3, 8)),
                        ($urandom_range(7) == 0) ? DIM_W'($urandom_range(2))
                                                 : DIM_W'($urandom_range(3, 6)));
            end
            // Now and then a frame is abandoned part way, so the next write lands mid-frame.
            cut = ($urandom_range(5) == 0) ? $urandom_range(1, 20) : 0;
            stream_frame(cut);
         end
      end

      settle();
      $display("Sent %0d input beats and checked %0d result beats over %0d frame settings,",
               beats_sent, results_seen, settings_used);
      $display("with sender and receiver idling in turn and then running flat out.");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

[depth_hole_fill_median3x3.f]
+incdir+rtl
rtl/dhf_pkg.sv
rtl/dhf_front.sv
rtl/dhf_queue.sv
rtl/dhf_back.sv
rtl/depth_hole_fill_median3x3.sv
test/tb_top.sv
